>>> src/sigd_pkg.sv
// Shared widths, codes and constants of the sigmoid activation block.
`timescale 1ns / 1ps

package sigd_pkg;

  localparam int ValueW  = 16;
  localparam int TimeW   = 32;
  localparam int SlopeW  = 15;
  localparam int SigW    = 17;
  localparam int ResultW = 18;

  // Item modes
  localparam logic MODE_EVAL  = 1'b0;
  localparam logic MODE_DERIV = 1'b1;

  localparam logic [SlopeW-1:0]  SLOPE_RESET = 15'd4096;
  localparam logic [SigW-1:0]    ONE_Q16     = 17'd65536;
  localparam logic [ResultW-1:0] RESULT_MAX  = 18'd262143;

endpackage

>>> src/sigd_in_if.sv
// Input channel: valid/ready handshake carrying one evaluate or derivative request.
`timescale 1ns / 1ps

interface sigd_in_if;
  import sigd_pkg::*;

  logic                     valid;
  logic                     ready;
  logic                     mode;
  logic signed [ValueW-1:0] neuron_in;
  logic [TimeW-1:0]         network_time;

  modport source (output valid, output mode, output neuron_in, output network_time,
                  input ready);
  modport sink   (input valid, input mode, input neuron_in, input network_time,
                  output ready);
endinterface

>>> src/sigd_out_if.sv
// Output channel: valid/ready handshake carrying one sigmoid or derivative result.
`timescale 1ns / 1ps

interface sigd_out_if;
  import sigd_pkg::*;

  logic               valid;
  logic               ready;
  logic [ResultW-1:0] result_value;

  modport source (output valid, output result_value, input ready);
  modport sink   (input valid, input result_value, output ready);
endinterface

>>> src/sigmoid_activation_with_derivative.sv
// Top level: sigmoid with configurable slope, cached value and cached derivative.
//
// Usage:
//   in_i  : request transaction {mode, neuron_in (Q4.12), network_time}.
//           mode 0 evaluates s = 1/(1+exp(-slope*x)); mode 1 returns slope*s*(1-s).
//   out_o : one result transaction per request, result_value in unsigned Q2.16.
//   cfg_we_i/cfg_wdata_i : write the slope register (unsigned Q3.12, reset 1.0), only while idle.
// Requests run through one shared 33x18 multiplier and one sigmoid ROM read port
// that fetches both interpolation points in turn:
//   - evaluate with a newer time stamp: three multiplies, two ROM reads
//   - first derivative after a fresh evaluation: two multiplies, rounding
//   - cached answer (stale time stamp, repeated derivative): no multiply, read from the cache
// One request is in flight at a time; in_i.ready rises again in the cycle after the
// result moves to the output register, so the next request is taken while a result
// still waits for out_o.ready. A stalled receiver holds the result and the sequencer
// waits before overwriting it.
// Reset clears the time stamp, both cached values and the fresh flag, and sets slope
// to 1.0. The sigmoid ROM is a constant table; it needs no fill after reset.
`timescale 1ns / 1ps

module sigmoid_activation_with_derivative #(
  parameter int TABLE_ENTRIES = 256
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [sigd_pkg::SlopeW-1:0] cfg_wdata_i,
  sigd_in_if.sink               in_i,
  sigd_out_if.source            out_o
);
  import sigd_pkg::*;

  localparam int AddrW = $clog2(TABLE_ENTRIES + 1);
  localparam logic [63:0] ONE_Q31 = 64'h0000_0000_8000_0000;
  localparam logic [46:0] DERIV_RND = 47'h000_0800_0000;

  // ---------------------------------------------------------------------------
  // Sigmoid ROM, built at elaboration
  // ---------------------------------------------------------------------------
  typedef logic [SigW-1:0] rom_t [TABLE_ENTRIES+1];

  function automatic logic [63:0] div_u64(input logic [63:0] num, input logic [63:0] den);
    logic [63:0] q;
    logic [64:0] r;
    q = '0;
    r = '0;
    for (int b = 63; b >= 0; b--) begin
      r = {r[63:0], num[b]};
      if (r >= {1'b0, den}) begin
        r = r - {1'b0, den};
        q[b] = 1'b1;
      end
    end
    return q;
  endfunction

  // exp(-a) for a in Q31 up to 0.5, Taylor series, result Q31
  function automatic logic [63:0] exp_neg_small(input logic [63:0] a);
    logic [63:0] sum;
    logic [63:0] term;
    sum  = ONE_Q31;
    term = ONE_Q31;
    for (int k = 1; k <= 16; k++) begin
      term = div_u64((term * a) >> 31, 64'(k));
      if ((k & 1) != 0) sum = sum - term;
      else sum = sum + term;
    end
    return sum;
  endfunction

  function automatic rom_t build_rom();
    rom_t        rom;
    logic [63:0] num16;
    logic [63:0] n8;
    logic [63:0] mag;
    logic [63:0] e;
    logic [63:0] den;
    logic [63:0] v;
    logic        neg;
    n8 = 64'(8 * TABLE_ENTRIES);
    for (int i = 0; i <= TABLE_ENTRIES; i++) begin
      num16 = 64'(16 * i);
      if (num16 >= n8) begin
        mag = num16 - n8;
        neg = 1'b0;
      end else begin
        mag = n8 - num16;
        neg = 1'b1;
      end
      e = exp_neg_small((mag << 27) / TABLE_ENTRIES);
      for (int sq = 0; sq < 4; sq++) begin
        e = (e * e + 64'h0000_0000_4000_0000) >> 31;
      end
      den = ONE_Q31 + e;
      if (neg) v = div_u64((e << 16) + (den >> 1), den);
      else v = div_u64((64'd1 << 47) + (den >> 1), den);
      rom[i] = v[SigW-1:0];
    end
    return rom;
  endfunction

  localparam rom_t SIG_ROM = build_rom();

  // ---------------------------------------------------------------------------
  // Sequencer states
  // ---------------------------------------------------------------------------
  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_MZ     = 4'd1;
  localparam logic [3:0] S_POS    = 4'd2;
  localparam logic [3:0] S_RDLO   = 4'd3;
  localparam logic [3:0] S_RDHI   = 4'd4;
  localparam logic [3:0] S_INTERP = 4'd5;
  localparam logic [3:0] S_SUM    = 4'd6;
  localparam logic [3:0] S_MSC    = 4'd7;
  localparam logic [3:0] S_MSL    = 4'd8;
  localparam logic [3:0] S_DRND   = 4'd9;
  localparam logic [3:0] S_DONE   = 4'd10;

  logic [3:0]               state_q, state_d;
  logic [SlopeW-1:0]        slope_q;
  logic [TimeW-1:0]         last_time_q;
  logic [SigW-1:0]          sig_q;
  logic [ResultW-1:0]       deriv_q;
  logic                     fresh_q;
  logic signed [ValueW-1:0] x_q;
  logic [50:0]              prod_q;
  logic [AddrW-1:0]         idx_q;
  logic [15:0]              frac_q;
  logic [SigW-1:0]          rom_q;
  logic [SigW-1:0]          lo_q;
  logic [ResultW-1:0]       res_q;
  logic                     out_valid_q;
  logic [ResultW-1:0]       out_res_q;

  logic                     in_fire;
  logic                     out_free;

  assign in_i.ready        = (state_q == S_IDLE);
  assign in_fire           = in_i.valid && in_i.ready;
  assign out_free          = !out_valid_q || out_o.ready;
  assign out_o.valid       = out_valid_q;
  assign out_o.result_value = out_res_q;

  // ---------------------------------------------------------------------------
  // Shared multiplier operand select
  // ---------------------------------------------------------------------------
  logic signed [32:0] mul_a;
  logic signed [17:0] mul_b;
  logic signed [50:0] mul_p;
  logic [SigW-1:0]    diff;
  logic [SigW-1:0]    comp;
  logic signed [18:0] z;
  logic [15:0]        u;

  // Floor-shift the slope product back to Q4.12, clamp, bias to table position
  assign z = $signed(prod_q[30:12]);
  always_comb begin
    if (z < -19'sd32768) u = 16'h0000;
    else if (z > 19'sd32767) u = 16'hFFFF;
    else u = z[15:0] ^ 16'h8000;
  end

  assign diff = rom_q - lo_q;
  assign comp = (sig_q <= ONE_Q16) ? (ONE_Q16 - sig_q) : '0;

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_q)
      S_MZ: begin
        mul_a = {{17{x_q[15]}}, x_q};
        mul_b = {3'b000, slope_q};
      end
      S_POS: begin
        mul_a = {17'd0, u};
        mul_b = 18'(TABLE_ENTRIES);
      end
      S_INTERP: begin
        mul_a = {16'd0, diff};
        mul_b = {2'b00, frac_q};
      end
      S_MSC: begin
        mul_a = {16'd0, sig_q};
        mul_b = {1'b0, comp};
      end
      S_MSL: begin
        mul_a = {2'b00, prod_q[30:0]};
        mul_b = {3'b000, slope_q};
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign mul_p = mul_a * mul_b;

  // ---------------------------------------------------------------------------
  // ROM read port: low point, then high point
  // ---------------------------------------------------------------------------
  logic [AddrW-1:0] rom_addr;

  always_comb begin
    if (state_q == S_RDHI) rom_addr = idx_q + 1'b1;
    else rom_addr = prod_q[16 +: AddrW];
  end

  always_ff @(posedge clk_i) begin
    rom_q <= SIG_ROM[rom_addr];
  end

  // ---------------------------------------------------------------------------
  // Rounding of interpolation and derivative
  // ---------------------------------------------------------------------------
  logic [33:0]        interp_rnd;
  logic [SigW-1:0]    sig_new;
  logic [46:0]        deriv_rnd;
  logic [18:0]        deriv_raw;
  logic [ResultW-1:0] deriv_new;

  assign interp_rnd = prod_q[33:0] + 34'd32768;
  assign sig_new    = SigW'({1'b0, lo_q} + interp_rnd[33:16]);
  assign deriv_rnd  = prod_q[46:0] + DERIV_RND;
  assign deriv_raw  = deriv_rnd[46:28];
  assign deriv_new  = (deriv_raw > {1'b0, RESULT_MAX}) ? RESULT_MAX : deriv_raw[ResultW-1:0];

  // ---------------------------------------------------------------------------
  // Next state
  // ---------------------------------------------------------------------------
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (in_fire) begin
          if (in_i.mode == MODE_EVAL) begin
            state_d = (in_i.network_time > last_time_q) ? S_MZ : S_DONE;
          end else begin
            state_d = fresh_q ? S_MSC : S_DONE;
          end
        end
      end
      S_MZ:     state_d = S_POS;
      S_POS:    state_d = S_RDLO;
      S_RDLO:   state_d = S_RDHI;
      S_RDHI:   state_d = S_INTERP;
      S_INTERP: state_d = S_SUM;
      S_SUM:    state_d = S_DONE;
      S_MSC:    state_d = S_MSL;
      S_MSL:    state_d = S_DRND;
      S_DRND:   state_d = S_DONE;
      S_DONE: begin
        if (out_free) state_d = S_IDLE;
      end
      default:  state_d = S_IDLE;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Control and cache registers
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      slope_q     <= SLOPE_RESET;
      last_time_q <= '0;
      sig_q       <= '0;
      deriv_q     <= '0;
      fresh_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;

      // Take a slope write
      if (cfg_we_i) slope_q <= cfg_wdata_i;

      // Advance the time stamp as soon as a newer evaluate is taken
      if (in_fire && in_i.mode == MODE_EVAL && in_i.network_time > last_time_q) begin
        last_time_q <= in_i.network_time;
      end

      // Store the fresh sigmoid
      if (state_q == S_SUM) begin
        sig_q   <= sig_new;
        fresh_q <= 1'b1;
      end

      // Store the derivative and drop the fresh flag
      if (state_q == S_DRND) begin
        deriv_q <= deriv_new;
        fresh_q <= 1'b0;
      end

      // Hold the output until the receiver takes it
      if (state_q == S_DONE && out_free) out_valid_q <= 1'b1;
      else if (out_o.ready) out_valid_q <= 1'b0;
    end
  end

  // ---------------------------------------------------------------------------
  // Datapath registers
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      x_q <= in_i.neuron_in;
      // Cached answers are ready at once
      if (in_i.mode == MODE_EVAL) res_q <= {1'b0, sig_q};
      else res_q <= deriv_q;
    end

    if (state_q == S_MZ || state_q == S_POS || state_q == S_INTERP ||
        state_q == S_MSC || state_q == S_MSL) begin
      prod_q <= mul_p;
    end

    if (state_q == S_RDLO) begin
      idx_q  <= rom_addr;
      frac_q <= prod_q[15:0];
    end

    if (state_q == S_RDHI) lo_q <= rom_q;

    if (state_q == S_SUM) res_q <= {1'b0, sig_new};
    if (state_q == S_DRND) res_q <= deriv_new;

    if (state_q == S_DONE && out_free) out_res_q <= res_q;
  end

endmodule

>>> tb/sigmoid_activation_with_derivative_tb.sv
// Self-checking testbench for the sigmoid activation block with cached value and derivative.
`timescale 1ns / 1ps

module sigmoid_activation_with_derivative_tb;
  import sigd_pkg::*;

  localparam int SigPoints = 256;
  localparam int IdleLimit = 2000;
  localparam int Phases    = 8;
  localparam int PhaseLen  = 210;

  typedef struct {
    logic                     mode;
    logic signed [ValueW-1:0] value;
    logic [TimeW-1:0]         stamp;
  } request_t;

  logic               clk_i;
  logic               rst_ni;
  logic               cfg_we_i;
  logic [SlopeW-1:0]  cfg_wdata_i;

  sigd_in_if  in_if ();
  sigd_out_if out_if ();

  sigmoid_activation_with_derivative #(
    .TABLE_ENTRIES(SigPoints)
  ) u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_i        (in_if),
    .out_o       (out_if)
  );

  // Predictor state: slope register, time stamp, cached values, fresh flag
  longint unsigned    sig_points [SigPoints+1];
  logic [SlopeW-1:0]  m_slope;
  logic [TimeW-1:0]   m_last_stamp;
  logic [SigW-1:0]    m_sigmoid;
  logic [ResultW-1:0] m_derivative;
  logic               m_fresh;

  request_t           request_q [$];
  logic [ResultW-1:0] result_due_q [$];

  int requests_queued;
  int requests_taken;
  int results_seen;
  int mismatches;
  int fresh_evals;
  int cached_evals;
  int new_derivs;
  int cached_derivs;
  int idle_cycles;

  int unsigned send_wait;
  int unsigned recv_wait;
  bit          send_burst;
  bit          recv_burst;

  // Build the sigmoid points at z_i = -8 + 16*i/N with a Q31 exponential
  function automatic void build_sig_points();
    longint unsigned n, num16, mag, a, e, den, sum, term;
    bit neg;
    n = SigPoints;
    for (int i = 0; i <= SigPoints; i++) begin
      num16 = 64'd16 * longint'(i);
      neg   = (num16 < 64'd8 * n);
      mag   = neg ? (64'd8 * n - num16) : (num16 - 64'd8 * n);
      // exp(-|z|/16) by Taylor series, then square four times
      a    = (mag << 27) / n;
      sum  = 64'd1 << 31;
      term = 64'd1 << 31;
      for (longint unsigned k = 1; k <= 16; k++) begin
        term = ((term * a) >> 31) / k;
        if (k[0]) sum = sum - term;
        else      sum = sum + term;
      end
      e = sum;
      for (int sq = 0; sq < 4; sq++) begin
        e = (e * e + (64'd1 << 30)) >> 31;
      end
      den = (64'd1 << 31) + e;
      if (neg) sig_points[i] = ((e << 16) + den / 2) / den;
      else     sig_points[i] = ((64'd1 << 47) + den / 2) / den;
    end
  endfunction

  // Advance the predictor by one accepted transaction and return its result
  function automatic logic [ResultW-1:0] predict_result(
    input logic                     mode,
    input logic signed [ValueW-1:0] value,
    input logic [TimeW-1:0]         stamp
  );
    longint          sl, xv, prod, z;
    longint unsigned pos, idx, frac, lo, hi, s, c, d, slu;
    if (mode == MODE_EVAL) begin
      if (stamp > m_last_stamp) begin
        sl   = m_slope;
        xv   = value;
        prod = sl * xv;
        // Q7.24 to Q4.12, floor, then clamp to the table range
        z = prod >>> 12;
        if (z < -32768) z = -32768;
        if (z > 32767)  z = 32767;
        pos  = longint'(z + 32768) * SigPoints;
        idx  = pos >> 16;
        frac = pos & 64'hFFFF;
        lo   = sig_points[idx];
        hi   = sig_points[idx + 1];
        m_sigmoid    = SigW'(lo + (((hi - lo) * frac + 64'd32768) >> 16));
        m_last_stamp = stamp;
        m_fresh      = 1'b1;
        fresh_evals++;
      end else begin
        cached_evals++;
      end
      return {1'b0, m_sigmoid};
    end
    if (m_fresh) begin
      slu = m_slope;
      s   = m_sigmoid;
      c   = (s <= 64'd65536) ? (64'd65536 - s) : 64'd0;
      d   = (slu * s * c + (64'd1 << 27)) >> 28;
      if (d > RESULT_MAX) d = RESULT_MAX;
      m_derivative = ResultW'(d);
      m_fresh      = 1'b0;
      new_derivs++;
    end else begin
      cached_derivs++;
    end
    return m_derivative;
  endfunction

  task automatic queue_request(input logic mode, input logic signed [ValueW-1:0] value,
                               input logic [TimeW-1:0] stamp);
    request_t req;
    req.mode  = mode;
    req.value = value;
    req.stamp = stamp;
    request_q.push_back(req);
    requests_queued++;
  endtask

  // Hold until every request is taken and answered, then let the pipeline drain
  task automatic wait_idle();
    while (requests_taken != requests_queued || result_due_q.size() != 0) @(posedge clk_i);
    repeat (12) @(posedge clk_i);
  endtask

  task automatic write_slope(input logic [SlopeW-1:0] value);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    m_slope = value;
  endtask

  // Clock
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Drive request transactions from the pending queue with random gaps
  always @(posedge clk_i) begin : drive_requests
    request_t req;
    if (!rst_ni) begin
      in_if.valid <= 1'b0;
      send_wait   <= 0;
    end else begin
      if (in_if.valid && in_if.ready) begin
        result_due_q.push_back(predict_result(in_if.mode, in_if.neuron_in,
                                              in_if.network_time));
        requests_taken++;
      end
      if (!in_if.valid || in_if.ready) begin
        if (send_wait != 0) begin
          send_wait   <= send_wait - 1;
          in_if.valid <= 1'b0;
        end else if (request_q.size() != 0) begin
          req = request_q.pop_front();
          in_if.valid        <= 1'b1;
          in_if.mode         <= req.mode;
          in_if.neuron_in    <= req.value;
          in_if.network_time <= req.stamp;
          if ($urandom_range(0, 39) == 0) send_burst = !send_burst;
          send_wait <= send_burst ? 0 : $urandom_range(0, 15);
        end else begin
          in_if.valid <= 1'b0;
        end
      end
    end
  end

  // Take result transactions with random stalls and compare with the prediction
  always @(posedge clk_i) begin : check_results
    logic [ResultW-1:0] want;
    int unsigned        hold;
    if (!rst_ni) begin
      out_if.ready <= 1'b0;
      recv_wait    <= 0;
    end else if (out_if.valid && out_if.ready) begin
      if (result_due_q.size() == 0) begin
        $error("unexpected result transaction, result_value %0d", out_if.result_value);
        mismatches++;
      end else begin
        want = result_due_q.pop_front();
        if (want !== out_if.result_value) begin
          $error("result_value mismatch: expected %0d, actual %0d", want,
                 out_if.result_value);
          mismatches++;
        end
      end
      results_seen++;
      if ($urandom_range(0, 39) == 0) recv_burst = !recv_burst;
      hold = recv_burst ? 0 : $urandom_range(0, 15);
      recv_wait    <= hold;
      out_if.ready <= (hold == 0);
    end else if (recv_wait != 0) begin
      recv_wait    <= recv_wait - 1;
      out_if.ready <= (recv_wait == 1);
    end else begin
      out_if.ready <= 1'b1;
    end
  end

  // Watchdog: drop the run when no transaction moves for too long
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= IdleLimit) begin
        $display("no transaction for %0d cycles, %0d of %0d requests taken",
                 IdleLimit, requests_taken, requests_queued);
        $display("SCOREBOARD MISMATCH");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  // Stimulus: directed corner cases, then random phases under several slopes
  initial begin
    logic [TimeW-1:0]         stamp_hi;
    logic [SlopeW-1:0]        phase_slope;
    logic signed [ValueW-1:0] xv;
    int unsigned              pick;

    rst_ni             = 1'b0;
    cfg_we_i           = 1'b0;
    cfg_wdata_i        = '0;
    in_if.valid        = 1'b0;
    in_if.mode         = MODE_EVAL;
    in_if.neuron_in    = '0;
    in_if.network_time = '0;
    out_if.ready       = 1'b0;
    requests_queued = 0;
    requests_taken  = 0;
    results_seen    = 0;
    mismatches      = 0;
    fresh_evals     = 0;
    cached_evals    = 0;
    new_derivs      = 0;
    cached_derivs   = 0;
    idle_cycles     = 0;
    send_burst      = 1'b0;
    recv_burst      = 1'b0;

    build_sig_points();
    m_slope      = SLOPE_RESET;
    m_last_stamp = '0;
    m_sigmoid    = '0;
    m_derivative = '0;
    m_fresh      = 1'b0;

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Reset slope: derivative before any evaluation, stamp not newer, midpoint, ends
    queue_request(MODE_DERIV, 16'sh7FFF, 32'hFFFF_FFFF);
    queue_request(MODE_EVAL, 16'sh1234, 32'd0);
    queue_request(MODE_EVAL, 16'sd0, 32'd1);
    queue_request(MODE_DERIV, -16'sd1, 32'd0);
    queue_request(MODE_DERIV, 16'sd0, 32'd0);
    queue_request(MODE_EVAL, 16'sd32767, 32'd2);
    queue_request(MODE_EVAL, -16'sd32768, 32'd3);
    queue_request(MODE_EVAL, -16'sd32768, 32'd3);
    queue_request(MODE_EVAL, 16'sd100, 32'd2);
    queue_request(MODE_DERIV, 16'sd0, 32'd0);
    queue_request(MODE_EVAL, 16'sd1, 32'd4);
    queue_request(MODE_EVAL, -16'sd1, 32'd5);
    queue_request(MODE_DERIV, 16'sd0, 32'd0);
    wait_idle();

    // Steepest slope: z clamps at both ends
    write_slope(15'h7FFF);
    queue_request(MODE_EVAL, 16'sd32767, 32'd6);
    queue_request(MODE_DERIV, 16'sd0, 32'd0);
    queue_request(MODE_EVAL, -16'sd32768, 32'd7);
    queue_request(MODE_EVAL, -16'sd1, 32'd8);
    queue_request(MODE_EVAL, 16'sd1, 32'd9);
    queue_request(MODE_DERIV, 16'sd0, 32'd0);
    wait_idle();

    // Flattest nonzero slope
    write_slope(15'd1);
    queue_request(MODE_EVAL, 16'sd32767, 32'd10);
    queue_request(MODE_EVAL, -16'sd32768, 32'd11);
    queue_request(MODE_EVAL, -16'sd1, 32'd12);
    queue_request(MODE_DERIV, 16'sd0, 32'd0);
    wait_idle();

    // Zero slope: sigmoid at one half, derivative zero
    write_slope(15'd0);
    queue_request(MODE_EVAL, 16'sd12345, 32'd13);
    queue_request(MODE_DERIV, 16'sd0, 32'd0);
    wait_idle();

    stamp_hi = 32'd13;
    for (int ph = 0; ph < Phases; ph++) begin
      case (ph)
        0: phase_slope = SLOPE_RESET;
        1: phase_slope = 15'h7FFF;
        2: phase_slope = 15'd1;
        4: phase_slope = SlopeW'($urandom_range(256, 4096));
        5: phase_slope = SlopeW'($urandom_range(4096, 16384));
        7: phase_slope = SLOPE_RESET;
        default: phase_slope = SlopeW'($urandom_range(1, 32767));
      endcase
      write_slope(phase_slope);
      // Push the time stamps up so the high bits get exercised too
      if (ph == Phases - 1) stamp_hi = 32'hFFF0_0000;
      else                  stamp_hi = stamp_hi + (32'd1 << (4 * ph));

      for (int n = 0; n < PhaseLen; n++) begin
        pick = $urandom_range(0, 99);
        if (pick < 35) begin
          queue_request(MODE_DERIV, ValueW'($urandom), $urandom);
        end else begin
          pick = $urandom_range(0, 9);
          if (pick < 6) begin
            xv = ValueW'($urandom);
          end else if (pick < 8) begin
            xv = $signed(8'($urandom));
          end else begin
            case ($urandom_range(0, 4))
              0:       xv = -16'sd32768;
              1:       xv = 16'sd32767;
              2:       xv = -16'sd1;
              3:       xv = 16'sd1;
              default: xv = 16'sd0;
            endcase
          end
          pick = $urandom_range(0, 9);
          if (pick < 7) begin
            stamp_hi = stamp_hi + $urandom_range(1, 50);
            queue_request(MODE_EVAL, xv, stamp_hi);
          end else if (pick < 8) begin
            queue_request(MODE_EVAL, xv, stamp_hi);
          end else begin
            queue_request(MODE_EVAL, xv, $urandom_range(0, stamp_hi));
          end
        end
      end
      wait_idle();
    end

    // Top of the time stamp range, then a repeat and an older stamp
    queue_request(MODE_EVAL, 16'sh0800, 32'hFFFF_FFFF);
    queue_request(MODE_EVAL, -16'sh0800, 32'hFFFF_FFFF);
    queue_request(MODE_DERIV, 16'sd0, 32'd0);
    queue_request(MODE_EVAL, 16'sd0, 32'd0);
    queue_request(MODE_DERIV, 16'sd0, 32'd0);

    while (requests_taken != requests_queued || result_due_q.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    if (result_due_q.size() != 0) begin
      $error("%0d predicted results never arrived", result_due_q.size());
      mismatches++;
    end

    $display("Ran %0d requests over %0d slope settings: %0d fresh and %0d cached evaluations,",
             requests_taken, Phases + 4, fresh_evals, cached_evals);
    $display("%0d recomputed and %0d cached derivatives; %0d results compared, %0d bad.",
             new_derivs, cached_derivs, results_seen, mismatches);
    if (mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

>>> sigmoid_activation_with_derivative.f
src/sigd_pkg.sv
src/sigd_in_if.sv
src/sigd_out_if.sv
src/sigmoid_activation_with_derivative.sv
tb/sigmoid_activation_with_derivative_tb.sv
